// ----- src/lbbc_pkg.sv -----
package lbbc_pkg;

  localparam int unsigned CmdW = 2;
  localparam int unsigned DevW = 8;
  localparam int unsigned BlkW = 32;
  localparam int unsigned IdxW = 5;
  localparam int unsigned StW  = 3;
  localparam int unsigned CntW = 8;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_EVICT  = 3'd1,
    ST_NO_REF    = 3'd2,
    ST_NO_PIN    = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request
    logic search;  // register hit / victim search results
    logic commit;  // apply state update and build result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic dummy_ok;
  } stat_t;

endpackage

// ----- src/lbbc_datapath.sv -----
module lbbc_datapath #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lbbc_pkg::ctrl_t        ctrl_i,
  output lbbc_pkg::stat_t        stat_o,
  input  logic [1:0]             cmd_i,
  input  logic [7:0]             device_i,
  input  logic [31:0]            block_number_i,
  input  logic [4:0]             entry_index_i,
  output logic [4:0]             entry_out_o,
  output logic                   hit_o,
  output logic                   needs_fill_o,
  output logic [2:0]             status_o
);
  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [7:0]    tdev_q  [ENTRIES];
  logic [31:0]   tblk_q  [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [7:0]    ref_q   [ENTRIES];
  logic [7:0]    pin_q   [ENTRIES];
  logic [EW-1:0] ord_q   [ENTRIES];

  logic [1:0]  cmd_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  logic [4:0]  idx_q;

  // per-position match / free flags, registered in the search step
  logic [ENTRIES-1:0] mpos_d, mpos_q, fpos_d, fpos_q;
  logic [ENTRIES-1:0] valid_d;
  logic        hfound, vfound;
  logic [EW-1:0] hent, vent;

  always_comb begin
    for (int p = 0; p < ENTRIES; p++) begin
      mpos_d[p] = (tdev_q[ord_q[p]] == dev_q) && (tblk_q[ord_q[p]] == blk_q);
      fpos_d[p] = (ref_q[ord_q[p]] == '0) && (pin_q[ord_q[p]] == '0);
    end
  end

  // first match from the front, first free from the back
  always_comb begin
    hfound = 1'b0;
    hent   = '0;
    vfound = 1'b0;
    vent   = '0;
    for (int p = ENTRIES - 1; p >= 0; p--) begin
      if (mpos_q[p]) begin
        hfound = 1'b1;
        hent   = ord_q[p];
      end
    end
    for (int p = 0; p < ENTRIES; p++) begin
      if (fpos_q[p]) begin
        vfound = 1'b1;
        vent   = ord_q[p];
      end
    end
  end

  logic          in_range;
  logic [EW-1:0] ix;
  logic          zero_rel;
  logic [EW:0]   mpos;

  assign in_range = ({27'd0, idx_q} < 32'(ENTRIES));
  assign ix       = EW'(idx_q);
  assign zero_rel = (cmd_q == lbbc_pkg::CMD_RELEASE) && in_range && (ref_q[ix] == 8'd1);

  always_comb begin
    mpos = (EW+1)'(ENTRIES);
    for (int p = ENTRIES - 1; p >= 0; p--) begin
      if (ord_q[p] == ix) mpos = (EW+1)'(p);
    end
  end

  assign valid_d = valid_q;
  assign stat_o.dummy_ok = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tdev_q[i] <= '0;
        tblk_q[i] <= '0;
        ref_q[i]  <= '0;
        pin_q[i]  <= '0;
        ord_q[i]  <= EW'(ENTRIES - 1 - i);
      end
    end else if (ctrl_i.commit) begin
      if (cmd_q == lbbc_pkg::CMD_GET) begin
        if (hfound) begin
          if (ref_q[hent] != lbbc_pkg::CntMax) begin
            ref_q[hent]   <= ref_q[hent] + 8'd1;
            valid_q[hent] <= 1'b1;
          end
        end else if (vfound) begin
          tdev_q[vent]  <= dev_q;
          tblk_q[vent]  <= blk_q;
          ref_q[vent]   <= 8'd1;
          valid_q[vent] <= 1'b1;
        end
      end else if (in_range) begin
        case (cmd_q)
          lbbc_pkg::CMD_RELEASE: begin
            if (ref_q[ix] != '0) ref_q[ix] <= ref_q[ix] - 8'd1;
            if (zero_rel && mpos < (EW+1)'(ENTRIES)) begin
              for (int p = 1; p < ENTRIES; p++) begin
                if ((EW+1)'(p) <= mpos) ord_q[p] <= ord_q[p-1];
              end
              ord_q[0] <= ix;
            end
          end
          lbbc_pkg::CMD_PIN:
            if (pin_q[ix] != lbbc_pkg::CntMax) pin_q[ix] <= pin_q[ix] + 8'd1;
          lbbc_pkg::CMD_UNPIN:
            if (pin_q[ix] != '0) pin_q[ix] <= pin_q[ix] - 8'd1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      dev_q <= device_i;
      blk_q <= block_number_i;
      idx_q <= entry_index_i;
    end
    if (ctrl_i.search) begin
      mpos_q <= mpos_d;
      fpos_q <= fpos_d;
    end
    if (ctrl_i.commit) begin
      hit_o        <= 1'b0;
      needs_fill_o <= 1'b0;
      entry_out_o  <= idx_q;
      status_o     <= lbbc_pkg::ST_OK;
      if (cmd_q == lbbc_pkg::CMD_GET) begin
        if (hfound) begin
          entry_out_o <= 5'(hent);
          hit_o       <= 1'b1;
          if (ref_q[hent] == lbbc_pkg::CntMax) status_o <= lbbc_pkg::ST_SATURATED;
          else needs_fill_o <= ~valid_d[hent];
        end else if (vfound) begin
          entry_out_o  <= 5'(vent);
          needs_fill_o <= 1'b1;
        end else begin
          entry_out_o <= '0;
          status_o    <= lbbc_pkg::ST_NO_EVICT;
        end
      end else if (in_range) begin
        case (cmd_q)
          lbbc_pkg::CMD_RELEASE:
            if (ref_q[ix] == '0) status_o <= lbbc_pkg::ST_NO_REF;
          lbbc_pkg::CMD_PIN:
            if (pin_q[ix] == lbbc_pkg::CntMax) status_o <= lbbc_pkg::ST_SATURATED;
          lbbc_pkg::CMD_UNPIN:
            if (pin_q[ix] == '0) status_o <= lbbc_pkg::ST_NO_PIN;
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- src/lbbc_ctrl.sv -----
module lbbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  lbbc_pkg::stat_t stat_i,
  output lbbc_pkg::ctrl_t ctrl_o
);
  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_COMMIT, S_OUT} state_e;
  state_e state_q;

  // next item may load while the result waits only once it is taken
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign ctrl_o.load   = in_valid_i && in_ready_o;
  assign ctrl_o.search = (state_q == S_SEARCH);
  assign ctrl_o.commit = (state_q == S_COMMIT) && stat_i.dummy_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_SEARCH;
        S_SEARCH: state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_OUT;
        S_OUT:    if (out_ready_i) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/lru_block_buffer_cache_core.sv -----
// steps: request captured at input transfer, search registers tag compare and free flags,
// then commit picks the entry, updates state and registers the result shown as valid
// no new command is accepted until the previous result has been taken by the receiver
// reset: all tags, counts and valid bits zero, recency order in descending index order
module lru_block_buffer_cache_core #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  entry_out_o,
  output logic        hit_o,
  output logic        needs_fill_o,
  output logic [2:0]  status_o
);
  lbbc_pkg::ctrl_t ctrl;
  lbbc_pkg::stat_t stat;

  lbbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  lbbc_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .cmd_i, .device_i,
    .block_number_i, .entry_index_i, .entry_out_o, .hit_o, .needs_fill_o, .status_o
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  a_commit_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |=> out_valid_o) else $error("result not shown after commit");
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && needs_fill_o) |-> (status_o == lbbc_pkg::ST_OK))
    else $error("fill with error status");
`endif
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NumEnt = 32;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [4:0]  entry_index;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  entry_out;
  logic        hit;
  logic        needs_fill;
  logic [2:0]  status;

  lru_block_buffer_cache_core #(.ENTRIES(NumEnt)) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .device_i       (device),
    .block_number_i (block_number),
    .entry_index_i  (entry_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .entry_out_o    (entry_out),
    .hit_o          (hit),
    .needs_fill_o   (needs_fill),
    .status_o       (status)
  );

  typedef struct packed {
    logic [4:0]        entry;
    logic              hit;
    logic              fill;
    lbbc_pkg::status_e st;
  } reply_t;

  typedef struct {
    lbbc_pkg::cmd_e op;
    logic [7:0]     dev;
    logic [31:0]    blk;
    logic [4:0]     idx;
    bit             typed;
    reply_t         want;
  } cmd_row_t;

  // shadow of the tag table
  logic [7:0]  sh_dev   [NumEnt];
  logic [31:0] sh_blk   [NumEnt];
  logic        sh_valid [NumEnt];
  logic [7:0]  sh_refs  [NumEnt];
  logic [7:0]  sh_pins  [NumEnt];
  logic [4:0]  sh_order [NumEnt];

  reply_t   pending_replies[$];
  cmd_row_t directed[$];
  int       mismatches, replies_seen, hits_seen, fills_seen, errs_seen;
  bit       hold_off, long_stall;

  function automatic reply_t mk(logic [4:0] e, logic h, logic f, lbbc_pkg::status_e s);
    reply_t r;
    r.entry = e; r.hit = h; r.fill = f; r.st = s;
    return r;
  endfunction

  function automatic reply_t cache_apply(lbbc_pkg::cmd_e op, logic [7:0] dev,
                                         logic [31:0] blk, logic [4:0] idx);
    int p, q, e;
    if (op == lbbc_pkg::CMD_GET) begin
      for (p = 0; p < NumEnt; p++) begin
        e = sh_order[p];
        if (sh_dev[e] == dev && sh_blk[e] == blk) begin
          logic f;
          if (sh_refs[e] == lbbc_pkg::CntMax)
            return mk(5'(e), 1'b1, 1'b0, lbbc_pkg::ST_SATURATED);
          sh_refs[e]++;
          f = !sh_valid[e];
          sh_valid[e] = 1'b1;
          return mk(5'(e), 1'b1, f, lbbc_pkg::ST_OK);
        end
      end
      for (p = NumEnt - 1; p >= 0; p--) begin
        e = sh_order[p];
        if (sh_refs[e] == 0 && sh_pins[e] == 0) begin
          sh_dev[e] = dev; sh_blk[e] = blk; sh_refs[e] = 8'd1; sh_valid[e] = 1'b1;
          return mk(5'(e), 1'b0, 1'b1, lbbc_pkg::ST_OK);
        end
      end
      return mk('0, 1'b0, 1'b0, lbbc_pkg::ST_NO_EVICT);
    end
    case (op)
      lbbc_pkg::CMD_RELEASE: begin
        if (sh_refs[idx] == 0) return mk(idx, 1'b0, 1'b0, lbbc_pkg::ST_NO_REF);
        sh_refs[idx]--;
        if (sh_refs[idx] == 0) begin
          for (p = 0; p < NumEnt; p++) if (sh_order[p] == idx) break;
          for (q = p; q > 0; q--) sh_order[q] = sh_order[q-1];
          sh_order[0] = idx;
        end
      end
      lbbc_pkg::CMD_PIN: begin
        if (sh_pins[idx] == lbbc_pkg::CntMax)
          return mk(idx, 1'b0, 1'b0, lbbc_pkg::ST_SATURATED);
        sh_pins[idx]++;
      end
      default: begin
        if (sh_pins[idx] == 0) return mk(idx, 1'b0, 1'b0, lbbc_pkg::ST_NO_PIN);
        sh_pins[idx]--;
      end
    endcase
    return mk(idx, 1'b0, 1'b0, lbbc_pkg::ST_OK);
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      reply_t got, exp_r;
      got = mk(entry_out, hit, needs_fill, lbbc_pkg::status_e'(status));
      replies_seen++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = pending_replies.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: entry %0d/%0d hit %0d/%0d fill %0d/%0d status %0d/%0d",
                     exp_r.entry, got.entry, exp_r.hit, got.hit, exp_r.fill, got.fill,
                     exp_r.st, got.st);
        end
        if (got.hit) hits_seen++;
        if (got.fill) fills_seen++;
        if (got.st != lbbc_pkg::ST_OK) errs_seen++;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int k;
    out_ready = 1'b0;
    k = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off && !long_stall) begin
        long_stall <= 1'b1;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        out_ready <= 1'b1;
        hold_off = 1'b0;
      end else begin
        k++;
        if ((k / 150) % 3 == 2) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_cmd(lbbc_pkg::cmd_e op, logic [7:0] dev, logic [31:0] blk,
                          logic [4:0] idx);
    in_valid     <= 1'b1;
    cmd          <= op;
    device       <= dev;
    block_number <= blk;
    entry_index  <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(cache_apply(op, dev, blk, idx));
  endtask

  task automatic add_row(lbbc_pkg::cmd_e op, logic [7:0] dev, logic [31:0] blk,
                         logic [4:0] idx, bit typed, reply_t want);
    cmd_row_t r;
    r.op = op; r.dev = dev; r.blk = blk; r.idx = idx; r.typed = typed; r.want = want;
    directed.push_back(r);
  endtask

  initial begin
    int i, burst, n;
    reply_t dummy, pred;
    logic [7:0]  pool_dev[8];
    logic [31:0] pool_blk[8];
    lbbc_pkg::cmd_e op;
    in_valid = 1'b0; cmd = '0; device = '0; block_number = '0; entry_index = '0;
    rst_n = 1'b0;
    mismatches = 0; replies_seen = 0; hits_seen = 0; fills_seen = 0; errs_seen = 0;
    hold_off = 1'b0; long_stall = 1'b0;
    for (i = 0; i < NumEnt; i++) begin
      sh_dev[i] = '0; sh_blk[i] = '0; sh_valid[i] = 1'b0; sh_refs[i] = '0; sh_pins[i] = '0;
      sh_order[i] = 5'(NumEnt - 1 - i);
    end
    dummy = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero tag hits the most recent entry at reset but still needs a fill
    add_row(lbbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0, 1,
            mk(5'd31, 1'b1, 1'b1, lbbc_pkg::ST_OK));
    add_row(lbbc_pkg::CMD_GET, 8'hff, 32'hffff_ffff, 5'd0, 1,
            mk(5'd0, 1'b0, 1'b1, lbbc_pkg::ST_OK));
    add_row(lbbc_pkg::CMD_GET, 8'hff, 32'hffff_ffff, 5'd0, 1,
            mk(5'd0, 1'b1, 1'b0, lbbc_pkg::ST_OK));
    add_row(lbbc_pkg::CMD_RELEASE, '0, '0, 5'd5, 1,
            mk(5'd5, 1'b0, 1'b0, lbbc_pkg::ST_NO_REF));
    add_row(lbbc_pkg::CMD_UNPIN, '0, '0, 5'd31, 1,
            mk(5'd31, 1'b0, 1'b0, lbbc_pkg::ST_NO_PIN));
    add_row(lbbc_pkg::CMD_PIN, '0, '0, 5'd31, 1,
            mk(5'd31, 1'b0, 1'b0, lbbc_pkg::ST_OK));
    add_row(lbbc_pkg::CMD_RELEASE, '0, '0, 5'd31, 0, dummy);
    add_row(lbbc_pkg::CMD_RELEASE, '0, '0, 5'd0, 0, dummy);
    add_row(lbbc_pkg::CMD_RELEASE, '0, '0, 5'd0, 0, dummy);
    add_row(lbbc_pkg::CMD_GET, 8'h12, 32'h8000_0001, 5'd0, 0, dummy);
    add_row(lbbc_pkg::CMD_UNPIN, '0, '0, 5'd31, 0, dummy);
    add_row(lbbc_pkg::CMD_GET, 8'h80, 32'h0000_0001, 5'h1f, 0, dummy);
    add_row(lbbc_pkg::CMD_PIN, '0, '0, 5'd16, 0, dummy);
    add_row(lbbc_pkg::CMD_UNPIN, '0, '0, 5'd16, 0, dummy);
    foreach (directed[j]) begin
      pred = cache_apply(directed[j].op, directed[j].dev, directed[j].blk, directed[j].idx);
      if (directed[j].typed && pred !== directed[j].want)
        $display("note: table row %0d disagrees with predictor", j);
    end
    for (i = 0; i < NumEnt; i++) begin
      sh_dev[i] = '0; sh_blk[i] = '0; sh_valid[i] = 1'b0; sh_refs[i] = '0; sh_pins[i] = '0;
      sh_order[i] = 5'(NumEnt - 1 - i);
    end
    foreach (directed[j]) begin
      send_cmd(directed[j].op, directed[j].dev, directed[j].blk, directed[j].idx);
      if (directed[j].typed) pending_replies[$] = directed[j].want;
    end

    // take every free entry, then further gets find nothing to evict
    for (i = 0; i < NumEnt; i++) send_cmd(lbbc_pkg::CMD_GET, 8'h40, 32'h1000 + i, '0);
    send_cmd(lbbc_pkg::CMD_GET, 8'h41, 32'h5, '0);
    send_cmd(lbbc_pkg::CMD_GET, 8'h40, 32'h1000, '0);
    // saturate a pin counter on entry 7
    for (i = 0; i < 256; i++) send_cmd(lbbc_pkg::CMD_PIN, '0, '0, 5'd7);
    for (i = 0; i < 256; i++) send_cmd(lbbc_pkg::CMD_UNPIN, '0, '0, 5'd7);
    in_valid <= 1'b0;
    // sender pauses until all results are back
    while (pending_replies.size() != 0) @(posedge clk);

    for (i = 0; i < 8; i++) begin
      pool_dev[i] = 8'($urandom); pool_blk[i] = $urandom;
    end
    hold_off = 1'b1;
    n = 0;
    while (n < 500) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: op = lbbc_pkg::CMD_GET;
          4, 5, 6:    op = lbbc_pkg::CMD_RELEASE;
          7:          op = lbbc_pkg::CMD_PIN;
          default:    op = lbbc_pkg::CMD_UNPIN;
        endcase
        if ($urandom_range(0, 4) == 0) begin
          send_cmd(op, 8'($urandom), $urandom, 5'($urandom));
        end else begin
          i = $urandom_range(0, 7);
          send_cmd(op, pool_dev[i], pool_blk[i], 5'($urandom_range(0, 7)));
        end
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    // saturate a reference count through repeated hits
    for (i = 0; i < 257; i++) send_cmd(lbbc_pkg::CMD_GET, 8'hee, 32'hdead_beef, '0);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d results: %0d hits, %0d fills, %0d error statuses",
             replies_seen, hits_seen, fills_seen, errs_seen);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- lru_block_buffer_cache_core.f -----
src/lbbc_pkg.sv
src/lbbc_datapath.sv
src/lbbc_ctrl.sv
src/lru_block_buffer_cache_core.sv
bench/tb_top.sv
